FILE: design/nsp_pkg.sv
// Shared types and constants for the sounder sentence parser.
// Used by the classifier, the token queue, the parse engine and the top level.
`timescale 1ns / 1ps
`default_nettype none

package nsp_pkg;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    TK_DOLLAR,
    TK_EOL,
    TK_COMMA,
    TK_DIGIT,
    TK_PLUS,
    TK_MINUS,
    TK_POINT,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] ch;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } queue_head_t;

  // Sentence identifiers and kinds
  localparam int NUM_IDS = 5;
  localparam int ID_LEN  = 5;
  localparam int KIND_W  = 3;

  localparam logic [KIND_W-1:0] KIND_DBT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DPT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MTW = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ZDA = 3'd3;
  localparam logic [KIND_W-1:0] KIND_XDR = 3'd4;

  localparam logic [0:NUM_IDS-1][0:ID_LEN-1][7:0] ID_TEXT =
    {"GPDBT", "GPDPT", "GPMTW", "GPZDA", "YXXDR"};

  localparam int NUM_VALUES = 5;
  localparam int VALUE_W    = 32;

  // Bit s set: field s+1 is reported for that kind
  localparam logic [0:NUM_IDS-1][NUM_VALUES-1:0] USED_FIELDS =
    {5'h05, 5'h07, 5'h01, 5'h1F, 5'h00};

  localparam int FIELD_IDX_W = 3;
  localparam logic [FIELD_IDX_W-1:0] FIELD_LAST = 3'd6;
  localparam logic [FIELD_IDX_W-1:0] FIELD_PAST = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]                   kind;
    logic [NUM_VALUES-1:0][VALUE_W-1:0]  value;
    logic                                saturated;
  } result_t;

  // Token queue, depth a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  function automatic logic [19:0] pow10(input logic [2:0] e);
    logic [19:0] p;
    case (e)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      default: p = 20'd1000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: design/nsp_classifier.sv
// Front end: sorts each received byte into a token class.
// Depends on nsp_pkg for the character codes and token type.
`timescale 1ns / 1ps
`default_nettype none

module nsp_classifier import nsp_pkg::*; (
  input  logic [7:0] rx_byte,
  output token_t     tok
);

  always_comb begin
    tok.ch = rx_byte;
    if (rx_byte == CH_DOLLAR) begin
      tok.kind = TK_DOLLAR;
    end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
      tok.kind = TK_EOL;
    end else if (rx_byte == CH_COMMA) begin
      tok.kind = TK_COMMA;
    end else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
      tok.kind = TK_DIGIT;
    end else if (rx_byte == CH_PLUS) begin
      tok.kind = TK_PLUS;
    end else if (rx_byte == CH_MINUS) begin
      tok.kind = TK_MINUS;
    end else if (rx_byte == CH_POINT) begin
      tok.kind = TK_POINT;
    end else begin
      tok.kind = TK_OTHER;
    end
  end

endmodule

`default_nettype wire

FILE: design/nsp_queue.sv
// Short token queue between the classifier and the parse engine.
// Depends on nsp_pkg for the token type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module nsp_queue import nsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  token_t      push_tok,
  output queue_head_t head,
  input  logic        pop
);

  token_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push       = push_valid && push_ready;
  assign head.valid = (cnt_r != '0);
  assign head.tok   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = QCNT_W'(cnt_r + {{(QCNT_W-1){1'b0}}, push} - {{(QCNT_W-1){1'b0}}, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

FILE: design/nsp_engine.sv
// Back end: sentence state machine, fixed-point field conversion and result register.
// Depends on nsp_pkg for tokens, identifier table and result type.
`timescale 1ns / 1ps
`default_nettype none

module nsp_engine import nsp_pkg::*; #(
  parameter int MAX_SENTENCE_LEN = 128,
  parameter int FRACTION_DIGITS  = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_head_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);

  localparam int POS_W = $clog2(MAX_SENTENCE_LEN + 1);
  localparam int FDS_W = $clog2(FRACTION_DIGITS + 2);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ID,
    PH_FIELDS
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [NUM_IDS-1:0]      mask_r, mask_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [FIELD_IDX_W-1:0]  fidx_r, fidx_nxt;
  logic [31:0]             acc_r, acc_nxt;
  logic [FDS_W-1:0]        fds_r, fds_nxt;
  logic                    sign_r, sign_nxt;
  logic                    point_r, point_nxt;
  logic                    started_r, started_nxt;
  logic                    stopped_r, stopped_nxt;
  logic [VALUE_W-1:0]      field_r [NUM_VALUES];
  logic [VALUE_W-1:0]      field_nxt [NUM_VALUES];
  logic                    sat_r, sat_nxt;
  logic                    out_valid_r, out_valid_nxt;
  result_t                 res_r, res_nxt;

  logic                    kind_ok;
  logic [KIND_W-1:0]       kind_idx;
  logic                    emit_want;
  logic                    do_finish;
  logic [FIELD_IDX_W-1:0]  fin_slot;
  logic                    fin_wr;
  logic [2:0]              fin_exp;
  logic [51:0]             fin_mag;
  logic [VALUE_W-1:0]      fin_val;
  logic                    fin_sat;
  logic                    fin_sat_used;
  logic [35:0]             acc_push;
  logic [VALUE_W-1:0]      fv [NUM_VALUES];

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Lowest matching identifier; at most one bit survives the id characters
  always_comb begin
    kind_ok  = (mask_r != '0);
    kind_idx = KIND_XDR;
    for (int k = NUM_IDS - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        kind_idx = KIND_W'(k);
      end
    end
  end

  // Scale the field in hand to fixed point and clamp
  always_comb begin
    fin_slot = FIELD_IDX_W'(fidx_r - 1'b1);
    fin_wr   = (fidx_r != '0) && (fidx_r <= FIELD_IDX_W'(NUM_VALUES));
    fin_exp  = 3'(3'(FRACTION_DIGITS) - 3'(fds_r));
    fin_mag  = 52'(acc_r) * 52'(pow10(fin_exp));
    if (sign_r) begin
      fin_sat = (fin_mag > 52'h0_0000_8000_0000);
      fin_val = fin_sat ? 32'h8000_0000 : 32'(32'd0 - fin_mag[31:0]);
    end else begin
      fin_sat = (fin_mag > 52'h0_0000_7FFF_FFFF);
      fin_val = fin_sat ? 32'h7FFF_FFFF : fin_mag[31:0];
    end
    fin_sat_used = fin_sat && fin_wr && kind_ok && USED_FIELDS[kind_idx][fin_slot];
  end

  // acc * 10 + digit, clamped at all ones
  always_comb begin
    acc_push = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + 36'(head.tok.ch - CH_ZERO);
  end

  always_comb begin
    for (int s = 0; s < NUM_VALUES; s++) begin
      fv[s] = (fin_wr && fin_slot == FIELD_IDX_W'(s)) ? fin_val : field_r[s];
      if (!USED_FIELDS[kind_idx][s]) begin
        fv[s] = '0;
      end
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    mask_nxt      = mask_r;
    pos_nxt       = pos_r;
    fidx_nxt      = fidx_r;
    acc_nxt       = acc_r;
    fds_nxt       = fds_r;
    sign_nxt      = sign_r;
    point_nxt     = point_r;
    started_nxt   = started_r;
    stopped_nxt   = stopped_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    do_finish     = 1'b0;
    for (int s = 0; s < NUM_VALUES; s++) begin
      field_nxt[s] = field_r[s];
    end

    emit_want = head.valid && (head.tok.kind == TK_EOL) && (phase_r == PH_FIELDS) && kind_ok;
    // Hold only a terminator that has nowhere to put its result
    pop = head.valid && (!emit_want || !out_valid_r || out_ready);

    if (pop) begin
      case (phase_r)
        PH_HUNT: begin
          if (head.tok.kind == TK_DOLLAR) begin
            phase_nxt   = PH_ID;
            mask_nxt    = '1;
            pos_nxt     = '0;
            fidx_nxt    = '0;
            acc_nxt     = '0;
            fds_nxt     = '0;
            sign_nxt    = 1'b0;
            point_nxt   = 1'b0;
            started_nxt = 1'b0;
            stopped_nxt = 1'b0;
            sat_nxt     = 1'b0;
            for (int s = 0; s < NUM_VALUES; s++) begin
              field_nxt[s] = '0;
            end
          end
        end
        PH_ID, PH_FIELDS: begin
          if (head.tok.kind == TK_EOL) begin
            do_finish = (phase_r == PH_FIELDS);
            phase_nxt = PH_HUNT;
          end else if (pos_r >= POS_W'(MAX_SENTENCE_LEN)) begin
            // Over-length: drop the sentence
            phase_nxt = PH_HUNT;
          end else if (phase_r == PH_ID) begin
            for (int k = 0; k < NUM_IDS; k++) begin
              if (head.tok.ch != ID_TEXT[k][pos_r[2:0]]) begin
                mask_nxt[k] = 1'b0;
              end
            end
            pos_nxt = POS_W'(pos_r + 1'b1);
            if (pos_r == POS_W'(ID_LEN - 1)) begin
              phase_nxt   = PH_FIELDS;
              fidx_nxt    = '0;
              acc_nxt     = '0;
              fds_nxt     = '0;
              sign_nxt    = 1'b0;
              point_nxt   = 1'b0;
              started_nxt = 1'b0;
              stopped_nxt = 1'b0;
            end
          end else begin
            pos_nxt = POS_W'(pos_r + 1'b1);
            if (head.tok.kind == TK_COMMA) begin
              do_finish = 1'b1;
              if (fidx_r != FIELD_PAST) begin
                fidx_nxt = FIELD_IDX_W'(fidx_r + 1'b1);
              end
              acc_nxt     = '0;
              fds_nxt     = '0;
              sign_nxt    = 1'b0;
              point_nxt   = 1'b0;
              started_nxt = 1'b0;
              stopped_nxt = 1'b0;
            end else if (fidx_r != '0 && fidx_r <= FIELD_LAST && !stopped_r) begin
              case (head.tok.kind)
                TK_PLUS, TK_MINUS: begin
                  if (!started_r) begin
                    started_nxt = 1'b1;
                    sign_nxt    = (head.tok.kind == TK_MINUS);
                  end else begin
                    stopped_nxt = 1'b1;
                  end
                end
                TK_DIGIT: begin
                  started_nxt = 1'b1;
                  if (!point_r || fds_r < FDS_W'(FRACTION_DIGITS)) begin
                    acc_nxt = (acc_push[35:32] != '0) ? '1 : acc_push[31:0];
                  end
                  if (point_r && fds_r < FDS_W'(FRACTION_DIGITS)) begin
                    fds_nxt = FDS_W'(fds_r + 1'b1);
                  end
                end
                TK_POINT: begin
                  if (!point_r) begin
                    point_nxt   = 1'b1;
                    started_nxt = 1'b1;
                  end else begin
                    stopped_nxt = 1'b1;
                  end
                end
                default: begin
                  stopped_nxt = 1'b1;
                end
              endcase
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end

    if (do_finish) begin
      for (int s = 0; s < NUM_VALUES; s++) begin
        if (fin_wr && fin_slot == FIELD_IDX_W'(s)) begin
          field_nxt[s] = fin_val;
        end
      end
      if (fin_sat_used) begin
        sat_nxt = 1'b1;
      end
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && emit_want) begin
      out_valid_nxt     = 1'b1;
      res_nxt.kind      = kind_idx;
      res_nxt.saturated = sat_r || fin_sat_used;
      for (int s = 0; s < NUM_VALUES; s++) begin
        res_nxt.value[s] = fv[s];
      end
      // Depth below transducer reports feet and metres only
      if (kind_idx == KIND_DBT) begin
        res_nxt.value[1] = fv[2];
        res_nxt.value[2] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mask_r    <= mask_nxt;
    pos_r     <= pos_nxt;
    fidx_r    <= fidx_nxt;
    acc_r     <= acc_nxt;
    fds_r     <= fds_nxt;
    sign_r    <= sign_nxt;
    point_r   <= point_nxt;
    started_r <= started_nxt;
    stopped_r <= stopped_nxt;
    sat_r     <= sat_nxt;
    res_r     <= res_nxt;
    for (int s = 0; s < NUM_VALUES; s++) begin
      field_r[s] <= field_nxt[s];
    end
  end

endmodule

`default_nettype wire

FILE: design/nmea_sounder_sentence_parser_top.sv
// Top level of the sounder sentence parser: classifier, token queue and parse engine.
// Depends on nsp_pkg, nsp_classifier, nsp_queue and nsp_engine.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received character per beat and sustains one beat per clock unless
// the engine holds a terminator. Each character is classified on entry and
// written to a four-entry token queue; the parse engine retires one token per
// cycle while it is not holding a terminator, so a result lands in the output
// register at the same edge at which its CR or LF leaves the queue. The
// engine holds a terminator only while the previous result is still waiting
// in the output register, and the queue keeps accepting input until it fills.
// Values come out scaled by 10^FRACTION_DIGITS; sentences longer than
// MAX_SENTENCE_LEN characters after the dollar sign are dropped. No clearing
// pass after reset.
module nmea_sounder_sentence_parser_top import nsp_pkg::*; #(
  parameter int MAX_SENTENCE_LEN = 128,
  parameter int FRACTION_DIGITS  = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_sentence_kind,
  output logic signed [31:0]  out_value_a,
  output logic signed [31:0]  out_value_b,
  output logic signed [31:0]  out_value_c,
  output logic signed [31:0]  out_value_d,
  output logic signed [31:0]  out_value_e,
  output logic                out_value_saturated
);

  token_t      in_tok;
  queue_head_t head;
  logic        pop;
  result_t     res;

  nsp_classifier u_classifier (
    .rx_byte (in_rx_byte),
    .tok     (in_tok)
  );

  nsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_tok   (in_tok),
    .head       (head),
    .pop        (pop)
  );

  nsp_engine #(
    .MAX_SENTENCE_LEN (MAX_SENTENCE_LEN),
    .FRACTION_DIGITS  (FRACTION_DIGITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_sentence_kind   = res.kind;
  assign out_value_a         = res.value[0];
  assign out_value_b         = res.value[1];
  assign out_value_c         = res.value[2];
  assign out_value_d         = res.value[3];
  assign out_value_e         = res.value[4];
  assign out_value_saturated = res.saturated;

  // An accepted beat is in the queue at the next edge
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> head.valid)
    else $error("accepted beat missing from token queue");

  // A new result only follows a terminator leaving the queue
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop && head.tok.kind == TK_EOL))
    else $error("result raised without a terminator");

  // The engine never takes a token from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty token queue");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sentence_kind <= KIND_XDR)
    else $error("sentence kind out of range");

endmodule

`default_nettype wire
